### hdl/kpad_pkg.sv
// Shared types and constants for the keypad scan and code entry block.
package kpad_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       hit;
    logic [1:0] col;
  } match_t;

  localparam logic [3:0] ColPatA = 4'hE;
  localparam logic [3:0] ColPatB = 4'hD;
  localparam logic [3:0] ColPatC = 4'hB;

  localparam logic [3:0] KeyNone = 4'd0;
  localparam logic [3:0] KeyOne  = 4'd1;
  localparam logic [3:0] KeyTwo  = 4'd2;
  localparam logic [3:0] KeyStar = 4'd10;
  localparam logic [3:0] KeyHash = 4'd12;

  localparam logic [3:0] RowBase0 = 4'd1;
  localparam logic [3:0] RowStep  = 4'd3;

  localparam logic [3:0] IndOff  = 4'b0000;
  localparam logic [3:0] IndOne  = 4'b0001;
  localparam logic [3:0] IndTwo  = 4'b0010;
  localparam logic [3:0] IndStar = 4'b1000;

  localparam int ReadoutLimit = 20;

endpackage

### hdl/kpad_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kpad_ram #(
  parameter int Width = 4,
  parameter int Depth = 20,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/kpad_row_match.sv
// Shared column compare unit: finds the single pressed column in one row nibble.
module kpad_row_match (
  input  logic [3:0]      nibble_i,
  output kpad_pkg::match_t match_o
);

  always_comb begin
    match_o = '0;
    if (nibble_i == kpad_pkg::ColPatA) begin
      match_o.hit = 1'b1;
      match_o.col = 2'd0;
    end else if (nibble_i == kpad_pkg::ColPatB) begin
      match_o.hit = 1'b1;
      match_o.col = 2'd1;
    end else if (nibble_i == kpad_pkg::ColPatC) begin
      match_o.hit = 1'b1;
      match_o.col = 2'd2;
    end
  end

endmodule

### hdl/keypad_scan_code_entry_core.sv
// Top level: row-serial keypad decode, code buffer and submit readout sequencer.
// Ordinary scan: rows are compared one per cycle in ST_SCAN, then ST_APPLY emits the result once the output is free.
// Hash readout: per buffer entry one RAM read (ST_READ) then emit (ST_EMIT), min(BUFFER_DEPTH,20) beats.
// Throughput: one scan at a time; in_stall_o is low only while the sequencer is idle.
// Reset: asynchronous, clears control state, key history, index, indicator and fill bits.
// Buffer entries with a clear fill bit read as zero, so no clearing pass is needed.
module keypad_scan_code_entry_core #(
  parameter int BUFFER_DEPTH = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] row0_columns_i,
  input  logic [3:0] row1_columns_i,
  input  logic [3:0] row2_columns_i,
  input  logic [3:0] row3_columns_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] key_code_o,
  output logic       entry_submitted_o,
  output logic [3:0] indicator_pattern_o,
  output logic       digit_valid_o,
  output logic [4:0] digit_position_o,
  output logic [3:0] digit_value_o,
  output logic       last_of_run_o
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int IW = $clog2(BUFFER_DEPTH + 1);
  localparam int NumOut = (BUFFER_DEPTH < kpad_pkg::ReadoutLimit) ? BUFFER_DEPTH
                                                                 : kpad_pkg::ReadoutLimit;

  kpad_pkg::state_e state_q, state_d;
  logic [15:0]       rows_q, rows_d;
  logic [1:0]        row_q, row_d;
  logic [3:0]        base_q, base_d;
  logic [3:0]        scanned_q, scanned_d;
  logic [3:0]        prev_q, prev_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [3:0]        ind_q, ind_d;
  logic [BUFFER_DEPTH-1:0] filled_q, filled_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              filled_rd_q;

  logic              out_valid_q, out_valid_d;
  logic [3:0]        key_q, key_d;
  logic              sub_q, sub_d;
  logic [3:0]        oind_q, oind_d;
  logic              dv_q, dv_d;
  logic [4:0]        pos_q, pos_d;
  logic [3:0]        val_q, val_d;
  logic              last_q, last_d;

  logic [3:0]        nibble;
  kpad_pkg::match_t  match;
  logic [3:0]        key;
  logic              out_free;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [3:0]        ram_rdata;

  always_comb begin
    unique case (row_q)
      2'd0:    nibble = rows_q[3:0];
      2'd1:    nibble = rows_q[7:4];
      2'd2:    nibble = rows_q[11:8];
      default: nibble = rows_q[15:12];
    endcase
  end

  kpad_row_match u_match (
    .nibble_i (nibble),
    .match_o  (match)
  );

  assign ram_waddr = AW'(idx_q);
  assign ram_raddr = AW'(cnt_q);

  kpad_ram #(
    .Width (4),
    .Depth (BUFFER_DEPTH),
    .AddrW (AW)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign key = (scanned_q != prev_q) ? scanned_q : kpad_pkg::KeyNone;

  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    row_d       = row_q;
    base_d      = base_q;
    scanned_d   = scanned_q;
    prev_d      = prev_q;
    idx_d       = idx_q;
    ind_d       = ind_q;
    filled_d    = filled_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    key_d       = key_q;
    sub_d       = sub_q;
    oind_d      = oind_q;
    dv_d        = dv_q;
    pos_d       = pos_q;
    val_d       = val_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    in_stall_o  = 1'b1;

    unique case (state_q)
      kpad_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          rows_d  = {row3_columns_i, row2_columns_i, row1_columns_i, row0_columns_i};
          row_d   = 2'd0;
          base_d  = kpad_pkg::RowBase0;
          state_d = kpad_pkg::ST_SCAN;
        end
      end
      kpad_pkg::ST_SCAN: begin
        if (match.hit) begin
          scanned_d = base_q + {2'b00, match.col};
          state_d   = kpad_pkg::ST_APPLY;
        end else if (row_q == 2'd3) begin
          scanned_d = kpad_pkg::KeyNone;
          state_d   = kpad_pkg::ST_APPLY;
        end else begin
          row_d  = row_q + 2'd1;
          base_d = base_q + kpad_pkg::RowStep;
        end
      end
      kpad_pkg::ST_APPLY: begin
        if (key == kpad_pkg::KeyHash) begin
          prev_d  = scanned_q;
          idx_d   = '0;
          ind_d   = kpad_pkg::IndOff;
          cnt_d   = '0;
          state_d = kpad_pkg::ST_READ;
        end else if (out_free) begin
          prev_d = scanned_q;
          if (key == kpad_pkg::KeyStar) begin
            filled_d = '0;
            idx_d    = '0;
            ind_d    = kpad_pkg::IndStar;
          end else if (key != kpad_pkg::KeyNone) begin
            if (key == kpad_pkg::KeyOne) ind_d = kpad_pkg::IndOne;
            if (key == kpad_pkg::KeyTwo) ind_d = kpad_pkg::IndTwo;
            if (idx_q < IW'(BUFFER_DEPTH)) begin
              ram_we              = 1'b1;
              filled_d[ram_waddr] = 1'b1;
              idx_d               = idx_q + IW'(1);
            end
          end
          out_valid_d = 1'b1;
          key_d       = key;
          sub_d       = 1'b0;
          oind_d      = ind_d;
          dv_d        = 1'b0;
          pos_d       = '0;
          val_d       = '0;
          last_d      = 1'b1;
          state_d     = kpad_pkg::ST_IDLE;
        end
      end
      kpad_pkg::ST_READ: begin
        ram_re  = 1'b1;
        state_d = kpad_pkg::ST_EMIT;
      end
      kpad_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          key_d       = kpad_pkg::KeyHash;
          sub_d       = 1'b1;
          oind_d      = ind_q;
          dv_d        = 1'b1;
          pos_d       = cnt_q;
          val_d       = filled_rd_q ? ram_rdata : 4'd0;
          last_d      = (cnt_q == 5'(NumOut - 1));
          if (cnt_q == 5'(NumOut - 1)) begin
            state_d = kpad_pkg::ST_IDLE;
          end else begin
            cnt_d   = cnt_q + 5'd1;
            state_d = kpad_pkg::ST_READ;
          end
        end
      end
      default: state_d = kpad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpad_pkg::ST_IDLE;
      row_q       <= '0;
      base_q      <= kpad_pkg::RowBase0;
      prev_q      <= kpad_pkg::KeyNone;
      idx_q       <= '0;
      ind_q       <= kpad_pkg::IndOff;
      filled_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      base_q      <= base_d;
      prev_q      <= prev_d;
      idx_q       <= idx_d;
      ind_q       <= ind_d;
      filled_q    <= filled_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q    <= rows_d;
    scanned_q <= scanned_d;
    key_q     <= key_d;
    sub_q     <= sub_d;
    oind_q    <= oind_d;
    dv_q      <= dv_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    last_q    <= last_d;
    if (ram_re) begin
      filled_rd_q <= filled_q[ram_raddr];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign key_code_o          = key_q;
  assign entry_submitted_o   = sub_q;
  assign indicator_pattern_o = oind_q;
  assign digit_valid_o       = dv_q;
  assign digit_position_o    = pos_q;
  assign digit_value_o       = val_q;
  assign last_of_run_o       = last_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IW'(BUFFER_DEPTH))
    else $error("entry index beyond buffer depth");

  a_readout_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dv_q |-> key_q == kpad_pkg::KeyHash && sub_q && oind_q == kpad_pkg::IndOff)
    else $error("readout beat carries wrong key or indicator");

  a_readout_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dv_q && last_q |-> pos_q == 5'(NumOut - 1))
    else $error("readout run ends at wrong position");

  a_ordinary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !dv_q |-> last_q && !sub_q && pos_q == 5'd0)
    else $error("ordinary beat not marked last");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == kpad_pkg::ST_SCAN && row_q == 2'd0)
    else $error("scan did not start from row zero");

endmodule

### tb/sv/keypad_scan_code_entry_core_tb.sv
// Self-checking testbench for the keypad scan decoder and code entry buffer.
module keypad_scan_code_entry_core_tb;

  localparam int Depth = 20;
  localparam int ReadoutLen = (Depth < kpad_pkg::ReadoutLimit) ? Depth : kpad_pkg::ReadoutLimit;
  localparam int RandomScans = 140;
  localparam int LongHold = 150;
  localparam int EndDrain = 60;
  localparam logic [3:0] KeyZero = 4'd11;

  typedef struct packed {
    logic [15:0] rows;
    logic [3:0]  gap;
    logic        drain;
  } scan_item_t;

  typedef struct packed {
    logic [3:0] key;
    logic       submitted;
    logic [3:0] ind;
    logic       dvalid;
    logic [4:0] pos;
    logic [3:0] val;
    logic       last;
  } report_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [3:0] row0_columns_i = 4'hF;
  logic [3:0] row1_columns_i = 4'hF;
  logic [3:0] row2_columns_i = 4'hF;
  logic [3:0] row3_columns_i = 4'hF;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [3:0] key_code_o;
  logic       entry_submitted_o;
  logic [3:0] indicator_pattern_o;
  logic       digit_valid_o;
  logic [4:0] digit_position_o;
  logic [3:0] digit_value_o;
  logic       last_of_run_o;

  scan_item_t pending_scans[$];
  report_t    expected_reports[$];

  logic [3:0] held_key = kpad_pkg::KeyNone;
  int         fill_count = 0;
  logic [3:0] stored_codes [Depth];
  logic [3:0] ind_bits = kpad_pkg::IndOff;

  int          fail_count = 0;
  int          scan_total = 0;
  int          report_count = 0;
  bit          quiet_tx = 1'b0;
  bit          quiet_rx = 1'b0;
  logic [3:0]  gap_left = 4'd0;
  logic        gap_done = 1'b0;
  int unsigned stall_left = 0;

  keypad_scan_code_entry_core #(
    .BUFFER_DEPTH(Depth)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .row0_columns_i     (row0_columns_i),
    .row1_columns_i     (row1_columns_i),
    .row2_columns_i     (row2_columns_i),
    .row3_columns_i     (row3_columns_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .key_code_o         (key_code_o),
    .entry_submitted_o  (entry_submitted_o),
    .indicator_pattern_o(indicator_pattern_o),
    .digit_valid_o      (digit_valid_o),
    .digit_position_o   (digit_position_o),
    .digit_value_o      (digit_value_o),
    .last_of_run_o      (last_of_run_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic report_t make_report(logic [3:0] key, logic submitted, logic [3:0] ind,
                                          logic dvalid, logic [4:0] pos, logic [3:0] val,
                                          logic last);
    make_report = {key, submitted, ind, dvalid, pos, val, last};
  endfunction

  function automatic logic [3:0] decode_rows(logic [15:0] rows);
    logic [3:0] nib;
    logic [3:0] base;
    for (int r = 0; r < 4; r++) begin
      nib = rows[4*r +: 4];
      base = kpad_pkg::RowBase0 + kpad_pkg::RowStep * 4'(r);
      if (nib == kpad_pkg::ColPatA) return base;
      if (nib == kpad_pkg::ColPatB) return base + 4'd1;
      if (nib == kpad_pkg::ColPatC) return base + 4'd2;
    end
    return kpad_pkg::KeyNone;
  endfunction

  function automatic void predict_scan(logic [15:0] rows);
    logic [3:0] scanned;
    logic [3:0] pressed;
    scanned = decode_rows(rows);
    pressed = kpad_pkg::KeyNone;
    if (scanned != held_key) begin
      pressed = scanned;
      held_key = scanned;
    end
    if (pressed == kpad_pkg::KeyHash) begin
      fill_count = 0;
      ind_bits = kpad_pkg::IndOff;
      for (int i = 0; i < ReadoutLen; i++) begin
        expected_reports.push_back(make_report(kpad_pkg::KeyHash, 1'b1, ind_bits, 1'b1, 5'(i),
                                               stored_codes[i], i == ReadoutLen - 1));
      end
      return;
    end
    if (pressed == kpad_pkg::KeyStar) begin
      for (int i = 0; i < Depth; i++) stored_codes[i] = kpad_pkg::KeyNone;
      fill_count = 0;
      ind_bits = kpad_pkg::IndStar;
    end else if (pressed != kpad_pkg::KeyNone) begin
      if (pressed == kpad_pkg::KeyOne) ind_bits = kpad_pkg::IndOne;
      if (pressed == kpad_pkg::KeyTwo) ind_bits = kpad_pkg::IndTwo;
      if (fill_count < Depth) begin
        stored_codes[fill_count] = pressed;
        fill_count++;
      end
    end
    expected_reports.push_back(make_report(pressed, 1'b0, ind_bits, 1'b0, 5'd0,
                                           kpad_pkg::KeyNone, 1'b1));
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_report(input report_t want, input report_t got);
    check_field("key_code", 32'(want.key), 32'(got.key));
    check_field("entry_submitted", 32'(want.submitted), 32'(got.submitted));
    check_field("indicator_pattern", 32'(want.ind), 32'(got.ind));
    check_field("digit_valid", 32'(want.dvalid), 32'(got.dvalid));
    check_field("digit_position", 32'(want.pos), 32'(got.pos));
    check_field("digit_value", 32'(want.val), 32'(got.val));
    check_field("last_of_run", 32'(want.last), 32'(got.last));
  endtask

  function automatic logic [3:0] idle_nibble();
    logic [3:0] n;
    do n = 4'($urandom_range(0, 15));
    while (n == kpad_pkg::ColPatA || n == kpad_pkg::ColPatB || n == kpad_pkg::ColPatC);
    return n;
  endfunction

  function automatic logic [15:0] release_scan();
    return {idle_nibble(), idle_nibble(), idle_nibble(), idle_nibble()};
  endfunction

  function automatic logic [15:0] key_scan(logic [3:0] code);
    logic [15:0] rows;
    int row;
    int col;
    row = (code - 1) / 3;
    col = (code - 1) % 3;
    rows = 16'($urandom);
    for (int r = 0; r < row; r++) rows[4*r +: 4] = idle_nibble();
    rows[4*row +: 4] = (col == 0) ? kpad_pkg::ColPatA :
                       (col == 1) ? kpad_pkg::ColPatB : kpad_pkg::ColPatC;
    return rows;
  endfunction

  task automatic add_scan(input logic [15:0] rows, input logic drain);
    scan_item_t it;
    it.rows = rows;
    it.gap = quiet_tx ? 4'd0 : 4'($urandom_range(0, 14));
    it.drain = drain;
    pending_scans.push_back(it);
    scan_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scan_driver
    scan_item_t nxt;
    logic offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 4'd0;
      gap_done <= 1'b0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_scan({row3_columns_i, row2_columns_i, row1_columns_i, row0_columns_i});
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 4'd0) begin
          gap_left <= gap_left - 4'd1;
          in_valid_i <= 1'b0;
        end else if (pending_scans.size() != 0 &&
                     !(pending_scans[0].drain && expected_reports.size() != 0)) begin
          if (!gap_done && pending_scans[0].gap != 4'd0) begin
            gap_left <= pending_scans[0].gap - 4'd1;
            gap_done <= 1'b1;
            in_valid_i <= 1'b0;
          end else begin
            nxt = pending_scans.pop_front();
            {row3_columns_i, row2_columns_i, row1_columns_i, row0_columns_i} <= nxt.rows;
            in_valid_i <= 1'b1;
            gap_done <= 1'b0;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : report_monitor
    report_t seen;
    int unsigned w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen = make_report(key_code_o, entry_submitted_o, indicator_pattern_o, digit_valid_o,
                           digit_position_o, digit_value_o, last_of_run_o);
        report_count++;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected beat, key_code %0d digit_position %0d",
                   $time, seen.key, seen.pos);
          fail_count++;
        end else begin
          compare_report(expected_reports.pop_front(), seen);
        end
        if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
        if (report_count == 30 || report_count == 300) w = LongHold;
        else if (quiet_rx) w = 0;
        else w = $urandom_range(0, 14);
        stall_left <= w;
        out_stall_i <= (w != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #5000000;
    $display("keypad_scan_code_entry_core_tb failed");
    $finish;
  end

  initial begin
    logic [3:0] d;
    int start;
    int n;
    int len;
    int ending;
    bit first;
    for (int i = 0; i < Depth; i++) stored_codes[i] = kpad_pkg::KeyNone;

    add_scan(key_scan(kpad_pkg::KeyHash), 1'b0);
    add_scan(16'hFFFF, 1'b0);
    add_scan(key_scan(kpad_pkg::KeyOne), 1'b0);
    add_scan(key_scan(kpad_pkg::KeyOne), 1'b0);
    add_scan(key_scan(kpad_pkg::KeyTwo), 1'b0);
    add_scan(key_scan(KeyZero), 1'b0);
    add_scan({4'hF, kpad_pkg::ColPatC, 4'hF, kpad_pkg::ColPatB}, 1'b0);
    add_scan(16'h7356, 1'b0);
    add_scan(16'h9AC0, 1'b0);
    for (d = kpad_pkg::KeyTwo + 4'd1; d < kpad_pkg::KeyStar; d++) add_scan(key_scan(d), 1'b0);
    add_scan(key_scan(kpad_pkg::KeyHash), 1'b1);
    add_scan(key_scan(kpad_pkg::KeyHash), 1'b0);
    add_scan(key_scan(kpad_pkg::KeyStar), 1'b0);
    add_scan(key_scan(kpad_pkg::KeyStar), 1'b0);
    add_scan(key_scan(kpad_pkg::KeyHash), 1'b0);
    add_scan(16'hFFFF, 1'b0);

    start = scan_total;
    first = 1'b1;
    while (scan_total - start < RandomScans) begin
      if ($urandom_range(0, 4) == 0) quiet_tx = !quiet_tx;
      if (!first && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) add_scan(16'($urandom), 1'b0);
      end else begin
        add_scan(release_scan(), $urandom_range(0, 5) == 0);
        if ($urandom_range(0, 1) == 1) add_scan(key_scan(kpad_pkg::KeyStar), 1'b0);
        len = (first || $urandom_range(0, 7) == 0) ? $urandom_range(18, 24)
                                                   : $urandom_range(0, 8);
        for (int k = 0; k < len; k++) begin
          d = 4'($urandom_range(1, 10));
          if (d == kpad_pkg::KeyStar) d = KeyZero;
          add_scan(key_scan(d), 1'b0);
          if ($urandom_range(0, 3) != 0) add_scan(release_scan(), 1'b0);
        end
        ending = $urandom_range(0, 9);
        if (ending < 8) add_scan(key_scan(kpad_pkg::KeyHash), 1'b0);
        else if (ending == 8) add_scan(key_scan(kpad_pkg::KeyStar), 1'b0);
        add_scan(release_scan(), 1'b0);
        first = 1'b0;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending_scans.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (EndDrain) @(posedge clk_i);
    if (fail_count == 0) $display("keypad_scan_code_entry_core_tb passed");
    else $display("keypad_scan_code_entry_core_tb failed");
    $finish;
  end

endmodule

### filelist.f
hdl/kpad_pkg.sv
hdl/kpad_ram.sv
hdl/kpad_row_match.sv
hdl/keypad_scan_code_entry_core.sv
tb/sv/keypad_scan_code_entry_core_tb.sv
